FILE: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, initial hash words, round constants and schedule functions for the message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_valid;
		logic       last_item;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       put;        // write put_byte into current lane
		logic [7:0] put_byte;
		logic       add_len;    // count 8 message bits
		logic       start;      // load working vars from hash words
		logic       round;      // one compression round
		logic       fold;       // add working vars into hash words
		logic       reinit;     // back to initial state
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [5:0]  byte_pos;
		logic [5:0]  round_idx;
		logic [63:0] bit_len;
	} dp_stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: design/sha_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer as a rolling 16-word schedule window, round unit, hash words.
// ----------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  dp_cmd_t        cmd,
	output dp_stat_t       stat,
	output logic [31:0]    hash_out [8]
);

	logic [31:0] hash_q [8];
	logic [31:0] var_q [8];
	logic [31:0] win_q [16];     // w[t..t+15]; byte fill writes lanes here too
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [63:0] len_q;

	logic [31:0] s1, ch, t1, s0, maj, w_new, a, e;
	logic [3:0]  widx;
	logic [4:0]  sh;

	assign a = var_q[0];
	assign e = var_q[4];
	always_comb begin
		s1    = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		ch    = (e & var_q[5]) ^ (~e & var_q[6]);
		t1    = var_q[7] + s1 + ch + ROUND_K[rnd_q] + win_q[0];
		s0    = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		maj   = (a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]);
		w_new = win_q[0] + sig0(win_q[1]) + win_q[9] + sig1(win_q[14]);
		widx  = pos_q[5:2];
		sh    = {~pos_q[1:0], 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= H_INIT[i];
			pos_q <= '0;
			rnd_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.reinit) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= H_INIT[i];
				len_q <= '0;
			end else if (cmd.add_len) begin
				len_q <= len_q + 64'd8;
			end
			if (cmd.put) pos_q <= pos_q + 6'd1;
			if (cmd.start) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold)
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (cmd.put)
			win_q[widx] <= (win_q[widx] & ~(32'hff << sh)) |
				({24'd0, cmd.put_byte} << sh);
		if (cmd.start)
			for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_new;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= e;
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= a;
			var_q[0] <= t1 + s0 + maj;
		end
	end

	assign stat.byte_pos  = pos_q;
	assign stat.round_idx = rnd_q;
	assign stat.bit_len   = len_q;
	assign hash_out       = hash_q;

endmodule

FILE: design/sha_control.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha_control import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_word_t   in_word,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       emit_valid,
	output logic [2:0] emit_idx,
	input  logic       emit_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	state_t      state_q, state_d;
	logic        pad_q, pad_d;      // in padding phase
	logic        fin_q, fin_d;      // last item seen
	logic        spill_q, spill_d;  // length does not fit, one more pad block
	logic [2:0]  idx_q, idx_d;
	logic        acc, full;
	logic [7:0]  len_byte;
	logic [2:0]  lsel;
	logic        lenblk_q;          // block being compressed carries the length

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
			spill_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			fin_q   <= fin_d;
			spill_q <= spill_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		lsel     = stat.byte_pos[2:0];
		len_byte = stat.bit_len[8*(7-lsel) +: 8];
	end

	always_comb begin
		state_d  = state_q;
		pad_d    = pad_q;
		fin_d    = fin_q;
		spill_d  = spill_q;
		idx_d    = idx_q;
		cmd      = '0;
		in_ready = 1'b0;
		acc      = 1'b0;
		full     = stat.byte_pos == 6'd63;
		emit_valid = 1'b0;
		emit_idx   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.put      = in_word.byte_valid;
					cmd.put_byte = in_word.message_byte;
					cmd.add_len  = in_word.byte_valid;
					fin_d        = in_word.last_item;
					if (in_word.byte_valid && full) begin
						cmd.start = 1'b1;
						state_d   = ST_ROUND;
					end else if (in_word.last_item) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				if (!pad_q) begin
					cmd.put_byte = PAD_BYTE;
					pad_d        = 1'b1;
					// marker in lanes 56..63: length goes into the next block
					if (stat.byte_pos >= 6'd56) spill_d = 1'b1;
				end else if (stat.byte_pos >= 6'd56 && !spill_q) begin
					cmd.put_byte = len_byte;
				end else begin
					cmd.put_byte = 8'h00;
				end
				if (full) begin
					cmd.start = 1'b1;
					spill_d   = 1'b0;
					state_d   = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_idx == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (lenblk_q) begin
					state_d = ST_EMIT;
					idx_d   = '0;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_EMIT: begin
				emit_valid = 1'b1;
				if (emit_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reinit = 1'b1;
						pad_d      = 1'b0;
						fin_d      = 1'b0;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lenblk_q <= 1'b0;
		else if (state_q == ST_PAD && full && pad_q && !spill_q) lenblk_q <= 1'b1;
		else if (state_q == ST_EMIT) lenblk_q <= 1'b0;
	end

endmodule

FILE: design/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// A message byte (or an empty word) is taken only in the idle state, not
// while a block is padded or compressed or the digest is offered. Each
// 64th byte starts a compression, one round a cycle in a single shared
// round unit, then a fold into the hash words; no input word is taken
// meanwhile. A last word pads the block one byte a cycle (two blocks when
// fewer than 8 lanes remain for the length), compresses, then offers the
// eight digest words, word 0 first, one per accepted output word. Output
// ready may stall freely; the block holds the digest until every word is taken.
// ----------------------------------------------------------------------------
module sha256_message_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	output out_word_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] hash_out [8];
	logic [2:0]  emit_idx;

	sha_control u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_word    (in_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.emit_valid (out_valid),
		.emit_idx   (emit_idx),
		.emit_ready (out_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sha_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.hash_out (hash_out)
	);

	// digest words come straight from the hash registers, stable while held
	assign out_data.digest_word = hash_out[emit_idx];
	assign out_data.word_index  = emit_idx;
	assign out_data.last_word   = emit_idx == 3'd7;

	// no input is taken while the digest is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input accepted during digest output");

	// rounds only run with the byte pointer at a block boundary
	a_round_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> stat.byte_pos == 6'd0)
		else $error("compression with partial block");

	// last word of the digest returns the length counter to zero
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last_word) |=> stat.bit_len == 64'd0)
		else $error("length not cleared after digest");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams byte messages into the hasher and checks every digest word against
// a bit-accurate SHA-256 predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import sha_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 300;

	logic      clk;
	logic      arst_n;
	in_word_t  in_data;
	logic      in_valid;
	logic      in_ready;
	out_word_t out_data;
	logic      out_valid;
	logic      out_ready;

	sha256_message_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	// idle odds in percent, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned words_sent;

	// predictor state
	logic [31:0] chain_hash [8];
	logic [31:0] msg_block [16];
	logic [63:0] msg_bits;
	logic [5:0]  lane;

	out_word_t digest_q [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < 8; i++)
			chain_hash[i] = H_INIT[i];
		msg_bits = '0;
		lane = '0;
	endfunction

	// 64 rounds over msg_block, folded into chain_hash
	function automatic void hash_compress();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, ch, maj, s0, s1;
		for (int i = 0; i < 16; i++)
			sched[i] = msg_block[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain_hash[i];
		for (int i = 0; i < 64; i++) begin
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_K[i] + sched[i];
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_hash[i] = chain_hash[i] + v[i];
	endfunction

	function automatic void hash_put(input logic [7:0] b);
		msg_block[lane[5:2]][8*(3-lane[1:0]) +: 8] = b;
		lane = lane + 6'd1;
		if (lane == 6'd0)
			hash_compress();
	endfunction

	// one accepted input word; a last word queues the eight digest words
	function automatic void hash_accept(input in_word_t w);
		logic [63:0] total;
		out_word_t   dw;
		if (w.byte_valid) begin
			msg_bits = msg_bits + 64'd8;
			hash_put(w.message_byte);
		end
		if (w.last_item) begin
			total = msg_bits;
			hash_put(PAD_BYTE);
			while (lane != 6'd56)
				hash_put(8'h00);
			for (int i = 0; i < 8; i++)
				hash_put(total[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				dw.digest_word = chain_hash[i];
				dw.word_index = 3'(i);
				dw.last_word = (i == 7);
				digest_q = {digest_q, dw};
			end
			hash_restart();
		end
	endfunction

	// input monitor: predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			hash_accept(in_data);
	end

	// output checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h idx %0d last %b",
						out_data.digest_word, out_data.word_index, out_data.last_word);
			end else begin
				want = digest_q.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
							want.digest_word, want.word_index, want.last_word,
							out_data.digest_word, out_data.word_index, out_data.last_word);
				end
			end
		end
	end

	// receiver backpressure
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// drive one word and hold it until taken
	task automatic send_word(input logic [7:0] b, input logic bv, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data.message_byte = b;
		in_data.byte_valid = bv;
		in_data.last_item = last;
		in_valid = 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		words_sent++;
	endtask

	// whole message; noise_pct inserts ignored empty words before bytes
	task automatic send_message(input int len, input bit empty_last, input int unsigned noise_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(8'($urandom), 1'b1, (i == len - 1) && !empty_last);
		end
		if (len == 0 || empty_last)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_empty_message();
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b1);
	endtask

	task automatic test_short_messages();
		// single extreme bytes, each ending the message
		send_word(8'hff, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		// "abc" with an ignored empty word after its first byte
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		// byte message closed by an empty last word
		send_word(8'h5a, 1'b1, 1'b0);
		send_word(8'ha5, 1'b0, 1'b1);
	endtask

	task automatic test_random_messages(input int unsigned target);
		int unsigned stop_at;
		int          len;
		int unsigned pick;
		stop_at = words_sent + target;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 75)
				len = $urandom_range(20);
			else if (pick < 95)
				len = $urandom_range(54, 66);  // padding and block boundaries
			else
				len = $urandom_range(110, 130); // 120..127 spill the length into an extra pad block
			// keep the phase close to its word budget
			if (len > int'(stop_at - words_sent))
				len = int'(stop_at - words_sent);
			send_message(len, $urandom_range(3) == 0, 10);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_pct = 12;
		recv_idle_pct = 77;
		mismatches = 0;
		cycles = 0;
		words_sent = 0;
		hash_restart();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_short_messages();
		test_random_messages(100);
		send_idle_pct = 77;
		recv_idle_pct = 12;
		test_random_messages(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(100);

		@(negedge clk);
		in_valid = 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && digest_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
